// ----- src/bdec_pkg.sv -----
// Shared types and codes for the base16/32/64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bdec_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_PAD   = 2'd2;

	// Base selector codes
	localparam logic [1:0] BASE16 = 2'd0;
	localparam logic [1:0] BASE32 = 2'd1;
	localparam logic [1:0] BASE64 = 2'd2;

	// Input command codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DATA      = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR  = 2'd2;
	localparam logic [1:0] ST_BAD_BLOCK = 2'd3;

	// Register reset values
	localparam logic [1:0] RST_BASE  = BASE64;
	localparam logic [1:0] RST_ALPHA = 2'd0;
	localparam logic       RST_PAD   = 1'b1;

	// Most result bytes a single request can cause
	localparam int MAX_RESULTS = 5;

	typedef struct packed {
		logic [1:0] base_select;
		logic [1:0] alphabet_select;
		logic       pad_enable;
	} bdec_cfg_t;

	// Results of one request: count, shared status and the bytes in order
	typedef struct packed {
		logic [2:0]                  n;
		logic [1:0]                  status;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} bdec_bundle_t;

endpackage

`default_nettype wire

// ----- src/base16_32_64_stream_decoder.sv -----
// Top level of the base16/32/64 stream decoder.
// The decoder takes one request per clock when it is not held off: an encoded character
// or an end-of-input marker. Each request is looked up and packed combinationally between
// the input register and the result register, and its results (up to five bytes for a
// full base32 group, three for base64, one for base16, or a single status) leave on the
// output one per cycle while m_tready is high. A request that causes several results
// holds the result register until its last result is taken; the request behind it waits
// in the input register until then, so the input is held off even when the output drains
// every cycle. Requests that give no result (a symbol that does not complete a group,
// padding, characters swallowed after an error) pass whenever the result register is
// free or handing out its last result. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module base16_32_64_stream_decoder (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] char_byte
	input  wire        s_tuser,   // [0] command
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [1:0] status
	output logic       m_tlast,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [1:0] cfg_data
);

	bdec_pkg::bdec_cfg_t    cfg_q;
	bdec_pkg::bdec_bundle_t bun;
	logic                   bun_valid;
	logic                   bun_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_select     <= bdec_pkg::RST_BASE;
			cfg_q.alphabet_select <= bdec_pkg::RST_ALPHA;
			cfg_q.pad_enable      <= bdec_pkg::RST_PAD;
		end else if (cfg_we) begin
			case (cfg_index)
				bdec_pkg::REG_BASE:  cfg_q.base_select     <= cfg_data;
				bdec_pkg::REG_ALPHA: cfg_q.alphabet_select <= cfg_data;
				bdec_pkg::REG_PAD:   cfg_q.pad_enable      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bdec_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg       (cfg_q),
		.bun_valid (bun_valid),
		.bun_ready (bun_ready),
		.bun       (bun)
	);

	bdec_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.bun_valid (bun_valid),
		.bun_ready (bun_ready),
		.bun       (bun),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

// ----- src/bdec_decode.sv -----
// Input register, symbol lookup, group store and byte packing.
`timescale 1ns / 1ps
`default_nettype none

module bdec_decode (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,
	input  wire                  s_tuser,
	input  bdec_pkg::bdec_cfg_t  cfg,
	output logic                 bun_valid,
	input  wire                  bun_ready,
	output bdec_pkg::bdec_bundle_t bun
);

	localparam logic [7:0] CH_PAD = 8'h3D;

	// Character to symbol: {hit, value}
	function automatic logic [6:0] lookup(input logic [1:0] kind, input logic [1:0] alpha,
			input logic [7:0] c);
		logic [7:0] v;
		logic       hit;
		v   = 8'd0;
		hit = 1'b0;
		case (kind)
			bdec_pkg::BASE16: begin
				if (c inside {[8'h30:8'h39]}) begin
					hit = 1'b1; v = c - 8'h30;
				end else if (c inside {[8'h41:8'h46]}) begin
					hit = 1'b1; v = c - 8'h41 + 8'd10;
				end
			end
			bdec_pkg::BASE32: begin
				if (alpha == 2'd1) begin
					if (c inside {[8'h30:8'h39]}) begin
						hit = 1'b1; v = c - 8'h30;
					end else if (c inside {[8'h41:8'h56]}) begin
						hit = 1'b1; v = c - 8'h41 + 8'd10;
					end
				end else begin
					if (c inside {[8'h41:8'h5A]}) begin
						hit = 1'b1; v = c - 8'h41;
					end else if (c inside {[8'h32:8'h37]}) begin
						hit = 1'b1; v = c - 8'h32 + 8'd26;
					end
				end
			end
			default: begin
				if (c inside {[8'h41:8'h5A]}) begin
					hit = 1'b1; v = c - 8'h41;
				end else if (c inside {[8'h61:8'h7A]}) begin
					hit = 1'b1; v = c - 8'h61 + 8'd26;
				end else if (c inside {[8'h30:8'h39]}) begin
					hit = 1'b1; v = c - 8'h30 + 8'd52;
				end else begin
					case (alpha)
						2'd1: begin
							if (c == 8'h2D) begin hit = 1'b1; v = 8'd62; end
							if (c == 8'h5F) begin hit = 1'b1; v = 8'd63; end
						end
						2'd2: begin
							if (c == 8'h2B) begin hit = 1'b1; v = 8'd62; end
							if (c == 8'h2C) begin hit = 1'b1; v = 8'd63; end
						end
						default: begin
							if (c == 8'h2B) begin hit = 1'b1; v = 8'd62; end
							if (c == 8'h2F) begin hit = 1'b1; v = 8'd63; end
						end
					endcase
				end
			end
		endcase
		return {hit, v[5:0]};
	endfunction

	// Pack the first n symbols MSB first; symbols are ORed in at their slot
	function automatic logic [4:0][7:0] pack(input logic [1:0] kind,
			input logic [7:0][5:0] syms, input logic [3:0] n);
		logic [9:0]      a16;
		logic [40:0]     a32;
		logic [23:0]     a64;
		logic [4:0][7:0] b;
		a16 = '0;
		a32 = '0;
		a64 = '0;
		b   = '0;
		for (int i = 0; i < 2; i++)
			if (4'(i) < n) a16 = a16 | (10'(syms[i]) << (4 * (1 - i)));
		for (int i = 0; i < 8; i++)
			if (4'(i) < n) a32 = a32 | (41'(syms[i]) << (5 * (7 - i)));
		for (int i = 0; i < 4; i++)
			if (4'(i) < n) a64 = a64 | (24'(syms[i]) << (6 * (3 - i)));
		case (kind)
			bdec_pkg::BASE16: b[0] = a16[7:0];
			bdec_pkg::BASE32: begin
				for (int j = 0; j < 5; j++) b[j] = a32[39 - 8 * j -: 8];
			end
			default: begin
				for (int j = 0; j < 3; j++) b[j] = a64[23 - 8 * j -: 8];
			end
		endcase
		return b;
	endfunction

	// Whole bytes in a partial group at end of input: {ok, count}
	function automatic logic [3:0] end_bytes(input logic [1:0] kind, input logic [3:0] n);
		logic [3:0] r;
		r = 4'b0000;
		case (kind)
			bdec_pkg::BASE16: if (n == 4'd2) r = {1'b1, 3'd1};
			bdec_pkg::BASE32: begin
				case (n)
					4'd2:    r = {1'b1, 3'd1};
					4'd4:    r = {1'b1, 3'd2};
					4'd5:    r = {1'b1, 3'd3};
					4'd7:    r = {1'b1, 3'd4};
					4'd8:    r = {1'b1, 3'd5};
					default: r = 4'b0000;
				endcase
			end
			default: begin
				case (n)
					4'd2:    r = {1'b1, 3'd1};
					4'd3:    r = {1'b1, 3'd2};
					4'd4:    r = {1'b1, 3'd3};
					default: r = 4'b0000;
				endcase
			end
		endcase
		return r;
	endfunction

	logic            valid_s1;
	logic            cmd_s1;
	logic [7:0]      char_s1;
	logic [3:0]      count_q;
	logic            pad_seen_q;
	logic            err_q;
	logic [7:0][5:0] grp_q;

	logic            commit;
	logic [1:0]      kind;
	logic [3:0]      gsize;
	logic [2:0]      full_n;
	logic [6:0]      lk;
	logic [7:0][5:0] merged;
	logic            pad_ok;
	logic [3:0]      cnt_inc;
	logic [3:0]      endv;
	logic [3:0]      count_d;
	logic            pad_d;
	logic            err_d;
	logic            grp_we;

	assign s_tready  = !valid_s1 || bun_ready;
	assign bun_valid = valid_s1;
	assign commit    = valid_s1 && bun_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (bun_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	// Base geometry; unused selector acts as base64
	always_comb begin
		kind = (cfg.base_select == 2'd3) ? bdec_pkg::BASE64 : cfg.base_select;
		case (kind)
			bdec_pkg::BASE16: begin gsize = 4'd2; full_n = 3'd1; end
			bdec_pkg::BASE32: begin gsize = 4'd8; full_n = 3'd5; end
			default:          begin gsize = 4'd4; full_n = 3'd3; end
		endcase
	end

	assign lk      = lookup(kind, cfg.alphabet_select, char_s1);
	assign cnt_inc = count_q + 4'd1;
	assign endv    = end_bytes(kind, count_q);
	assign pad_ok  = (char_s1 == CH_PAD) && cfg.pad_enable && (kind != bdec_pkg::BASE16)
		&& (pad_seen_q || count_q >= 4'd2);

	// Group with the incoming symbol dropped into its slot
	always_comb begin
		for (int i = 0; i < 8; i++)
			merged[i] = (3'(i) == count_q[2:0]) ? lk[5:0] : grp_q[i];
	end

	// Request decode: results and next state
	always_comb begin
		count_d    = count_q;
		pad_d      = pad_seen_q;
		err_d      = err_q;
		grp_we     = 1'b0;
		bun.n      = 3'd0;
		bun.status = bdec_pkg::ST_DATA;
		bun.bytes  = '0;
		if (cmd_s1 == bdec_pkg::CMD_END) begin
			if (err_q) begin
				bun.n = 3'd1; bun.status = bdec_pkg::ST_BAD_CHAR;
			end else if (count_q == 4'd0) begin
				bun.n = 3'd1; bun.status = bdec_pkg::ST_EMPTY;
			end else if (endv[3]) begin
				bun.n     = endv[2:0];
				bun.bytes = pack(kind, grp_q, count_q);
			end else begin
				bun.n = 3'd1; bun.status = bdec_pkg::ST_BAD_BLOCK;
			end
			count_d = 4'd0;
			pad_d   = 1'b0;
			err_d   = 1'b0;
		end else if (!err_q) begin
			if (pad_ok) begin
				pad_d = 1'b1;
			end else if (!lk[6] || pad_seen_q) begin
				err_d = 1'b1;
				bun.n = 3'd1; bun.status = bdec_pkg::ST_BAD_CHAR;
			end else begin
				grp_we = 1'b1;
				if (cnt_inc >= gsize) begin
					bun.n     = full_n;
					bun.bytes = pack(kind, merged, 4'd8);
					count_d   = 4'd0;
				end else begin
					count_d = cnt_inc;
				end
			end
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 4'd0;
			pad_seen_q <= 1'b0;
			err_q      <= 1'b0;
		end else if (commit) begin
			count_q    <= count_d;
			pad_seen_q <= pad_d;
			err_q      <= err_d;
		end
	end

	// Symbol store, no reset: only slots written in this group are read
	always_ff @(posedge clk) begin
		if (commit && grp_we)
			grp_q[count_q[2:0]] <= lk[5:0];
	end

endmodule

`default_nettype wire

// ----- src/bdec_serial.sv -----
// Result register that hands out a request's results one per cycle while m_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module bdec_serial (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    bun_valid,
	output logic                   bun_ready,
	input  bdec_pkg::bdec_bundle_t bun,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [7:0]             m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	logic                   valid_s2;
	bdec_pkg::bdec_bundle_t bun_s2;
	logic [2:0]             idx_q;
	logic                   last;

	assign last      = (idx_q == bun_s2.n - 3'd1);
	assign bun_ready = !valid_s2 || (m_tready && last);

	assign m_tvalid = valid_s2;
	assign m_tdata  = bun_s2.bytes[idx_q];
	assign m_tuser  = bun_s2.status;
	assign m_tlast  = last;

	// Load a new bundle, or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (bun_valid && bun_ready) begin
			valid_s2 <= (bun.n != 3'd0);
			idx_q    <= 3'd0;
		end else if (valid_s2 && m_tready) begin
			if (last) valid_s2 <= 1'b0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bun_valid && bun_ready)
			bun_s2 <= bun;
	end

endmodule

`default_nettype wire

// ----- src/bdec_checker.sv -----
// Port-level checks for the stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdec_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire [1:0] m_tuser,
	input wire       m_tlast
);

	// A stalled result holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Status results stand alone and carry a zero byte
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != bdec_pkg::ST_DATA) |-> m_tlast && (m_tdata == 8'd0))
		else $error("status result not alone or carries data");

	// Bytes of one request follow without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == bdec_pkg::ST_DATA))
		else $error("gap inside a burst of bytes");

	// Only data bytes can be followed by more results of the same request
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> m_tuser == bdec_pkg::ST_DATA)
		else $error("non-last result is not data");

endmodule

bind base16_32_64_stream_decoder bdec_checker u_bdec_checker (.*);

`default_nettype wire
